@@ design/balist_pkg.sv @@
// ----------------------------------------------------------------------------
// balist_pkg
// Shared types, sizes and codes for the bounded array list engine.
// ----------------------------------------------------------------------------
package balist_pkg;

  // Store size and derived widths
  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int OP_W      = 3;
  localparam int POS_W     = 8;
  localparam int DATA_W    = 32;
  localparam int ST_W      = 2;
  localparam int CAP_W     = 5;
  localparam int OUT_CNT_W = 5;

  // Compare widths
  localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int PCMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd1;
  localparam logic [OP_W-1:0] OP_POP    = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd4;
  localparam logic [OP_W-1:0] OP_READ   = 3'd5;

  // Result status codes
  localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
  localparam logic [ST_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [ST_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] STAT_RANGE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic [OUT_CNT_W-1:0]     element_count;
    logic signed [DATA_W-1:0] read_data;
    logic                     is_full;
    logic                     is_empty;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_DELETE,
    S_RDWAIT,
    S_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic            load_item;
    logic            ins_init;
    logic            ins_step;
    logic            ins_final;
    logic            push;
    logic            pop;
    logic            clr;
    logic            del_init;
    logic            del_step;
    logic            del_final;
    logic            rd_issue;
    logic            rd_capture;
    logic            err_en;
    logic [ST_W-1:0] err_code;
    logic            out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            rd_range;
    logic            ptr_gt_p;
    logic            pend;
    logic            scan_more;
    logic            out_free;
  } stat_t;

endpackage

@@ design/balist_ram.sv @@
// ----------------------------------------------------------------------------
// balist_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module balist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/balist_ctrl.sv @@
// ----------------------------------------------------------------------------
// balist_ctrl
// Operation sequencer: accepts one request, steps the datapath through it
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module balist_ctrl import balist_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FINISH;
        unique case (stat.op)
          OP_INSERT: begin
            if (stat.full) begin
              cmd.err_en   = 1'b1;
              cmd.err_code = STAT_FULL;
            end else begin
              cmd.ins_init = 1'b1;
              state_next   = S_SHIFT;
            end
          end
          OP_PUSH: begin
            if (stat.full) begin
              cmd.err_en   = 1'b1;
              cmd.err_code = STAT_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          OP_POP: begin
            if (stat.empty) begin
              cmd.err_en   = 1'b1;
              cmd.err_code = STAT_EMPTY;
            end else begin
              cmd.pop = 1'b1;
            end
          end
          OP_CLEAR: begin
            cmd.clr = 1'b1;
          end
          OP_DELETE: begin
            cmd.del_init = 1'b1;
            state_next   = S_DELETE;
          end
          OP_READ: begin
            if (stat.rd_range) begin
              cmd.err_en   = 1'b1;
              cmd.err_code = STAT_RANGE;
            end else begin
              cmd.rd_issue = 1'b1;
              state_next   = S_RDWAIT;
            end
          end
          default: begin
            // unused codes leave the list alone
          end
        endcase
      end
      S_SHIFT: begin
        if (stat.ptr_gt_p || stat.pend) begin
          cmd.ins_step = 1'b1;
        end else begin
          cmd.ins_final = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_DELETE: begin
        if (stat.scan_more || stat.pend) begin
          cmd.del_step = 1'b1;
        end else begin
          cmd.del_final = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_RDWAIT: begin
        cmd.rd_capture = 1'b1;
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Count-changing commands never overlap each other or the result load
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.ins_final, cmd.del_final, cmd.push, cmd.pop, cmd.clr, cmd.out_load}))
    else $error("overlapping count updates");

endmodule

@@ design/balist_dp.sv @@
// ----------------------------------------------------------------------------
// balist_dp
// List datapath: element store, count, capacity register, walk pointers and
// the result register.
// ----------------------------------------------------------------------------
module balist_dp import balist_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output stat_t            stat,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp
);

  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  // Control state
  logic [CNT_W-1:0] count;
  logic [CAP_W-1:0] capacity_limit;
  logic             pend;

  // Latched item and walk registers
  req_t                     item;
  logic [CNT_W-1:0]         ptr;
  logic [CNT_W-1:0]         kptr;
  logic [IDX_W-1:0]         wptr;
  logic [ST_W-1:0]          res_status;
  logic signed [DATA_W-1:0] res_data;

  // RAM connections
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Derived values
  logic [CMP_W-1:0]  cap_eff;
  logic [CMP_W-1:0]  cap_ext;
  logic              full;
  logic [PCMP_W-1:0] pos_ext;
  logic [PCMP_W-1:0] cnt_pext;
  logic [CNT_W-1:0]  p_clamp;
  logic              survivor;

  balist_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Saturate capacity to 1..DEPTH and clamp the insert position
  always_comb begin
    cap_ext = CMP_W'(capacity_limit);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > DEPTH_C) begin
      cap_eff = DEPTH_C;
    end else begin
      cap_eff = cap_ext;
    end
    full     = (CMP_W'(count) >= cap_eff);
    pos_ext  = PCMP_W'(item.position);
    cnt_pext = PCMP_W'(count);
    p_clamp  = (pos_ext > cnt_pext) ? count : CNT_W'(pos_ext);
    survivor = (ram_rdata != item.value);
  end

  // Status toward the controller
  always_comb begin
    stat.op        = item.operation;
    stat.full      = full;
    stat.empty     = (count == '0);
    stat.rd_range  = (pos_ext >= cnt_pext);
    stat.ptr_gt_p  = (ptr > p_clamp);
    stat.pend      = pend;
    stat.scan_more = (ptr < count);
    stat.out_free  = !rsp_valid || !rsp_stall;
  end

  // RAM port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wptr;
    ram_wdata = ram_rdata;
    ram_raddr = '0;
    if (cmd.ins_step) begin
      ram_raddr = IDX_W'(ptr - CNT_W'(1));
      ram_we    = pend;
    end
    if (cmd.ins_final) begin
      ram_we    = 1'b1;
      ram_waddr = IDX_W'(p_clamp);
      ram_wdata = item.value;
    end
    if (cmd.push) begin
      ram_we    = 1'b1;
      ram_waddr = IDX_W'(count);
      ram_wdata = item.value;
    end
    if (cmd.del_step) begin
      ram_raddr = IDX_W'(ptr);
      ram_we    = pend && survivor;
      ram_waddr = IDX_W'(kptr);
    end
    if (cmd.rd_issue) begin
      ram_raddr = IDX_W'(item.position);
    end
  end

  // Control registers: count, capacity, pending write, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      capacity_limit <= CAP_RESET;
      pend           <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity_limit <= cfg_data;
      end
      if (cmd.ins_init || cmd.del_init) begin
        pend <= 1'b0;
      end else if (cmd.ins_step) begin
        pend <= (ptr > p_clamp);
      end else if (cmd.del_step) begin
        pend <= (ptr < count);
      end
      if (cmd.ins_final || cmd.push) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop) begin
        count <= count - CNT_W'(1);
      end else if (cmd.clr) begin
        count <= '0;
      end else if (cmd.del_final) begin
        count <= kptr;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers: item, walk pointers, result
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item       <= req;
      res_status <= STAT_OK;
      res_data   <= '0;
    end
    if (cmd.err_en) begin
      res_status <= cmd.err_code;
    end
    if (cmd.rd_capture) begin
      res_data <= ram_rdata;
    end
    if (cmd.ins_init) begin
      ptr <= count;
    end else if (cmd.ins_step && (ptr > p_clamp)) begin
      ptr  <= ptr - CNT_W'(1);
      wptr <= IDX_W'(ptr);
    end
    if (cmd.del_init) begin
      ptr  <= '0;
      kptr <= '0;
    end else if (cmd.del_step) begin
      if (ptr < count) begin
        ptr <= ptr + CNT_W'(1);
      end
      if (pend && survivor) begin
        kptr <= kptr + CNT_W'(1);
      end
    end
    if (cmd.out_load) begin
      rsp.status        <= res_status;
      rsp.element_count <= OUT_CNT_W'(count);
      rsp.read_data     <= res_data;
      rsp.is_full       <= full;
      rsp.is_empty      <= (count == '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= DEPTH_C)
    else $error("count beyond store depth");

  a_grow_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.ins_final || cmd.push) |-> !full)
    else $error("list grown while full");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> rsp_valid)
    else $error("result load did not raise valid");

endmodule

@@ design/bounded_array_list_engine.sv @@
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Ordered list of signed 32-bit words in a 16-entry store with count,
// insert, push, pop, clear, delete-value and read operations.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  req       req_valid / req_stall  req_t  (operation, position, value)
//  rsp       rsp_valid / rsp_stall  rsp_t  (status, count, data, flags)
//  cfg       cfg_valid / cfg_ready  cfg_data (capacity_limit)
//
//  Every request passes from S_EXEC to S_FINISH; a read waits in S_RDWAIT,
//  a non-full insert shifts entries toward the tail in S_SHIFT and
//  delete-value walks the whole list in S_DELETE through the RAM's single
//  read port. One item is in work at a time: req_stall holds until its
//  result is loaded into the output register.
//  Reset (rst, synchronous) empties the list and sets capacity to 16; store
//  contents are not cleared. A stalled result holds in the output register.
// ----------------------------------------------------------------------------
module bounded_array_list_engine import balist_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // Capacity writes are always taken
  assign cfg_ready = 1'b1;

  balist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  balist_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
